// File: rtl/core/fnpm_pkg.sv
// Shared constants, types and helpers of the forward nearest-point matcher.
package fnpm_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;

  localparam int ACT_W      = 2;
  localparam int LAT_W      = 31;
  localparam int LON_W      = 32;
  localparam int MATCH_W    = 12;
  localparam int PT_W       = LAT_W + LON_W;

  localparam int DIFF_W     = LON_W + 1;
  localparam int ABS_W      = 31;
  localparam int SQ_W       = 2 * ABS_W - 1;
  localparam int DIST_W     = SQ_W + 1;

  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

  localparam logic signed [DIFF_W-1:0] DIFF_MAX = 33'sd1073741823;
  localparam logic signed [DIFF_W-1:0] DIFF_MIN = -33'sd1073741824;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } fnpm_tag_t;

  // saturate a difference to 31 signed bits and return its magnitude
  function automatic logic [ABS_W-1:0] sat_abs(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] s;
    logic signed [DIFF_W-1:0] m;
    if (d > DIFF_MAX) begin
      s = DIFF_MAX;
    end else if (d < DIFF_MIN) begin
      s = DIFF_MIN;
    end else begin
      s = d;
    end
    m = (s < 0) ? -s : s;
    return m[ABS_W-1:0];
  endfunction

endpackage

// File: rtl/core/fnpm_if.sv
// Valid/ready channel interfaces for the matcher's input and result sides.
interface fnpm_in_if import fnpm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [LAT_W-1:0] latitude;
  logic signed [LON_W-1:0] longitude;

  modport source (output valid, action, latitude, longitude, input ready);
  modport sink   (input valid, action, latitude, longitude, output ready);
endinterface

interface fnpm_out_if import fnpm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MATCH_W-1:0] matched_index;
  logic               empty_flag;

  modport source (output valid, matched_index, empty_flag, input ready);
  modport sink   (input valid, matched_index, empty_flag, output ready);
endinterface

// File: rtl/core/fnpm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module fnpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/fnpm_dist.sv
// Squared-distance pipeline: saturated differences, squares, sum.
module fnpm_dist import fnpm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    flush,
  input  fnpm_tag_t               iss_tag,
  input  logic [PT_W-1:0]         rd_point,
  input  logic signed [LAT_W-1:0] q_lat,
  input  logic signed [LON_W-1:0] q_lon,
  output fnpm_tag_t               dist_tag,
  output logic [DIST_W-1:0]       pt_dist
);

  fnpm_tag_t          tag1_r, tag2_r, tag3_r, tag4_r;
  logic [ABS_W-1:0]   ad_lat_r, ad_lon_r;
  logic [SQ_W-1:0]    sq_lat_r, sq_lon_r;
  logic [DIST_W-1:0]  dist_r;

  logic signed [LAT_W-1:0]  rd_lat;
  logic signed [LON_W-1:0]  rd_lon;
  logic signed [DIFF_W-1:0] d_lat, d_lon;

  assign rd_lat = rd_point[PT_W-1:LON_W];
  assign rd_lon = rd_point[LON_W-1:0];

  assign d_lat = DIFF_W'(rd_lat) - DIFF_W'(q_lat);
  assign d_lon = DIFF_W'(rd_lon) - DIFF_W'(q_lon);

  // tag1 lines up with the RAM's registered read data
  always_ff @(posedge clk) begin
    tag1_r.idx <= iss_tag.idx;
    tag2_r.idx <= tag1_r.idx;
    tag3_r.idx <= tag2_r.idx;
    tag4_r.idx <= tag3_r.idx;
    if (!rst_n || flush) begin
      tag1_r.vld <= 1'b0;
      tag2_r.vld <= 1'b0;
      tag3_r.vld <= 1'b0;
      tag4_r.vld <= 1'b0;
    end else begin
      tag1_r.vld <= iss_tag.vld;
      tag2_r.vld <= tag1_r.vld;
      tag3_r.vld <= tag2_r.vld;
      tag4_r.vld <= tag3_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    ad_lat_r   <= sat_abs(d_lat);
    ad_lon_r   <= sat_abs(d_lon);
    sq_lat_r   <= SQ_W'(ad_lat_r) * SQ_W'(ad_lat_r);
    sq_lon_r   <= SQ_W'(ad_lon_r) * SQ_W'(ad_lon_r);
    dist_r     <= DIST_W'(sq_lat_r) + DIST_W'(sq_lon_r);
  end

  assign dist_tag = tag4_r;
  assign pt_dist  = dist_r;

endmodule

// File: rtl/core/forward_nearest_point_matcher.sv
// Forward nearest-point matcher top level: control, track RAM and search.
//
// Input channel in_ch carries action, latitude and longitude. Action clear
// empties the track and zeroes the cursor; append writes the point at the
// end of the track (ignored when full); both give no result. A query
// walks the track forward from the cursor and yields one transfer on
// out_ch with the nearest point's index, or empty_flag set when the
// track is empty. Action code 3 is dropped.
// During a query walk one RAM read is issued per cycle and each read
// passes a four-stage pipeline (read, saturated difference, square, sum)
// before the compare that makes the early-stop decision. Reads in flight
// past the stop point are discarded. An empty-store query skips the walk
// and goes straight to the hold state that loads the result register.
// The block takes one item at a time; in_ch.ready is high while no query
// is in progress, so clears and appends still go in while a result waits.
// A stalled out_ch holds its result; a later query finishes its walk and
// then waits for the result register before the next item is taken.
// Reset (rst_n low, synchronous) empties the track and zeroes the cursor.
module forward_nearest_point_matcher import fnpm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  fnpm_in_if.sink    in_ch,
  fnpm_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        cursor_r, cursor_nxt;
  logic [CNT_W-1:0]        iss_r, iss_nxt;
  logic                    first_r, first_nxt;
  logic [DIST_W-1:0]       start_d_r, start_d_nxt;
  logic [DIST_W-1:0]       best_d_r, best_d_nxt;
  logic [IDX_W-1:0]        best_r, best_nxt;
  logic                    res_empty_r, res_empty_nxt;
  logic signed [LAT_W-1:0] q_lat_r;
  logic signed [LON_W-1:0] q_lon_r;

  logic                    out_vld_r, out_vld_nxt;
  logic [MATCH_W-1:0]      out_idx_r;
  logic                    out_empty_r;

  logic                    in_xfer;
  logic                    ram_we;
  logic [PT_W-1:0]         rd_point;
  fnpm_tag_t               iss_tag;
  fnpm_tag_t               dist_tag;
  logic [DIST_W-1:0]       pt_dist;
  logic                    done;
  logic                    is_last;
  logic                    out_free;
  logic [IDX_W-1:0]        start_idx;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign ram_we      = in_xfer && (in_ch.action == ACT_APPEND)
                       && (cnt_r < CNT_W'(MAX_POINTS));
  assign start_idx   = (CNT_W'(cursor_r) >= cnt_r) ? '0 : cursor_r;

  assign iss_tag = '{vld: (state_r == S_WALK) && (iss_r < cnt_r),
                     idx: iss_r[IDX_W-1:0]};

  assign out_free = !out_vld_r || out_ch.ready;
  assign is_last  = (CNT_W'(dist_tag.idx) + CNT_W'(1)) == cnt_r;

  fnpm_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_track (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata ({in_ch.latitude, in_ch.longitude}),
    .raddr (iss_r[IDX_W-1:0]),
    .rdata (rd_point)
  );

  fnpm_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .flush    (done),
    .iss_tag  (iss_tag),
    .rd_point (rd_point),
    .q_lat    (q_lat_r),
    .q_lon    (q_lon_r),
    .dist_tag (dist_tag),
    .pt_dist  (pt_dist)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cursor_nxt    = cursor_r;
    iss_nxt       = iss_r;
    first_nxt     = first_r;
    start_d_nxt   = start_d_r;
    best_d_nxt    = best_d_r;
    best_nxt      = best_r;
    res_empty_nxt = res_empty_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    done          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_ch.action)
            ACT_CLEAR: begin
              cnt_nxt    = '0;
              cursor_nxt = '0;
            end
            ACT_APPEND: begin
              if (ram_we) begin
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            ACT_QUERY: begin
              if (cnt_r == '0) begin
                res_empty_nxt = 1'b1;
                best_nxt      = '0;
                state_nxt     = S_HOLD;
              end else begin
                res_empty_nxt = 1'b0;
                iss_nxt       = CNT_W'(start_idx);
                first_nxt     = 1'b1;
                state_nxt     = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (iss_tag.vld) begin
          iss_nxt = iss_r + CNT_W'(1);
        end
        if (dist_tag.vld) begin
          if (first_r) begin
            first_nxt   = 1'b0;
            start_d_nxt = pt_dist;
            best_d_nxt  = pt_dist;
            best_nxt    = dist_tag.idx;
            done        = is_last;
          end else if ({1'b0, pt_dist} > {start_d_r, 1'b0}) begin
            // early stop: this point is past twice the cursor distance
            done = 1'b1;
          end else begin
            if (pt_dist < best_d_r) begin
              best_d_nxt = pt_dist;
              best_nxt   = dist_tag.idx;
            end
            done = is_last;
          end
          if (done) begin
            cursor_nxt = best_nxt;
            state_nxt  = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      cursor_r  <= '0;
      iss_r     <= '0;
      first_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      cursor_r  <= cursor_nxt;
      iss_r     <= iss_nxt;
      first_r   <= first_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_d_r   <= start_d_nxt;
    best_d_r    <= best_d_nxt;
    best_r      <= best_nxt;
    res_empty_r <= res_empty_nxt;
    if (in_xfer) begin
      q_lat_r <= in_ch.latitude;
      q_lon_r <= in_ch.longitude;
    end
    if (state_r == S_HOLD && out_free) begin
      out_idx_r   <= MATCH_W'(best_r);
      out_empty_r <= res_empty_r;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.matched_index = out_idx_r;
  assign out_ch.empty_flag    = out_empty_r;

endmodule

// File: dv/tb_forward_nearest_point_matcher.sv
// Testbench of the forward nearest-point matcher: directed rows and random tracks.
module tb_forward_nearest_point_matcher;
  import fnpm_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 1200000;
  localparam int          RX_HOLD_CYCLES = 400;
  localparam int          TAIL_CYCLES    = 40;
  localparam int          MAX_REPORTS    = 100;
  localparam longint      LAT_LIM        = 900000000;
  localparam longint      LON_LIM        = 1800000000;
  localparam longint      SAT_HI         = 64'sd1073741823;
  localparam longint      SAT_LO         = -64'sd1073741824;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [ACT_W-1:0]        action;
    logic signed [LAT_W-1:0] latitude;
    logic signed [LON_W-1:0] longitude;
  } track_item_t;

  typedef struct {
    logic [MATCH_W-1:0] matched_index;
    logic               empty_flag;
  } match_t;

  typedef struct {
    logic [ACT_W-1:0]        action;
    logic signed [LAT_W-1:0] latitude;
    logic signed [LON_W-1:0] longitude;
    bit                      typed;
    logic [MATCH_W-1:0]      matched_index;
    logic                    empty_flag;
  } dir_row_t;

  // action, latitude, longitude, typed, matched_index, empty_flag
  dir_row_t dir_tab [24] = '{
    '{ACT_QUERY,  0, 0, 1, 0, 1},                            // empty right after reset
    '{ACT_UNUSED, -1, -1, 0, 0, 0},
    '{ACT_APPEND, 900000000, 1800000000, 0, 0, 0},
    '{ACT_APPEND, -900000000, -1800000000, 0, 0, 0},
    '{ACT_QUERY,  -900000000, -1800000000, 1, 1, 0},         // both axes saturate at cursor
    '{ACT_QUERY,  900000000, 1800000000, 0, 0, 0},
    '{ACT_CLEAR,  0, 0, 0, 0, 0},
    '{ACT_QUERY,  0, 0, 1, 0, 1},
    '{ACT_APPEND, 0, 0, 0, 0, 0},
    '{ACT_APPEND, 100, 0, 0, 0, 0},
    '{ACT_APPEND, 100, 0, 0, 0, 0},
    '{ACT_APPEND, 0, 0, 0, 0, 0},
    '{ACT_QUERY,  100, 0, 0, 0, 0},                          // tie: earlier index kept
    '{ACT_QUERY,  0, 0, 0, 0, 0},
    '{ACT_CLEAR,  0, 0, 0, 0, 0},
    '{ACT_APPEND, 0, 0, 0, 0, 0},
    '{ACT_APPEND, 0, 1000, 0, 0, 0},
    '{ACT_APPEND, 0, 10, 0, 0, 0},
    '{ACT_QUERY,  0, 10, 0, 0, 0},                           // walk stops before nearer point
    '{ACT_APPEND, -1, -1, 0, 0, 0},
    '{ACT_QUERY,  0, 10, 0, 0, 0},
    '{ACT_UNUSED, 1, 1, 0, 0, 0},
    '{ACT_CLEAR,  0, 0, 0, 0, 0},
    '{ACT_QUERY,  5, 5, 1, 0, 1}
  };

  logic clk = 1'b0;
  logic rst_n;

  fnpm_in_if  in_if ();
  fnpm_out_if out_if ();

  forward_nearest_point_matcher DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #5 clk = ~clk;

  // track copy kept by the predictor
  logic signed [LON_W-1:0] trk_lat [MAX_POINTS];
  logic signed [LON_W-1:0] trk_lon [MAX_POINTS];
  int                      trk_count;
  int                      trk_cursor;

  match_t      pending_matches [$];
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          hold_rx_req;
  int unsigned sent_items;
  int unsigned cycle_count;
  int          errors;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("cycle %0d: mismatch: %s", cycle_count, msg);
    end
  endtask

  function automatic longint unsigned axis_sq(input longint a, input longint b);
    longint d;
    d = a - b;
    if (d > SAT_HI) d = SAT_HI;
    if (d < SAT_LO) d = SAT_LO;
    if (d < 0) d = -d;
    return longint'(unsigned'(d)) * longint'(unsigned'(d));
  endfunction

  function automatic longint unsigned point_dist(input int idx, input longint qlat,
                                                 input longint qlon);
    return axis_sq(longint'(trk_lat[idx]), qlat) + axis_sq(longint'(trk_lon[idx]), qlon);
  endfunction

  task automatic predict_match(input track_item_t it, input bit typed, input match_t typed_res);
    longint            qlat;
    longint            qlon;
    longint unsigned   start_d;
    longint unsigned   best_d;
    longint unsigned   d;
    int                best;
    match_t            res;
    qlat = longint'(it.latitude);
    qlon = longint'(it.longitude);
    case (it.action)
      ACT_CLEAR: begin
        trk_count  = 0;
        trk_cursor = 0;
      end
      ACT_APPEND: begin
        if (trk_count < MAX_POINTS) begin
          trk_lat[trk_count] = it.latitude;
          trk_lon[trk_count] = it.longitude;
          trk_count++;
        end
      end
      ACT_QUERY: begin
        res.matched_index = '0;
        res.empty_flag    = 1'b1;
        if (trk_count != 0) begin
          if (trk_cursor >= trk_count) trk_cursor = 0;
          start_d = point_dist(trk_cursor, qlat, qlon);
          best    = trk_cursor;
          best_d  = start_d;
          for (int i = trk_cursor + 1; i < trk_count; i++) begin
            d = point_dist(i, qlat, qlon);
            if (d > 2 * start_d) break;
            if (d < best_d) begin
              best   = i;
              best_d = d;
            end
          end
          trk_cursor        = best;
          res.matched_index = MATCH_W'(best);
          res.empty_flag    = 1'b0;
        end
        pending_matches = {pending_matches, (typed ? typed_res : res)};
      end
      default: ;
    endcase
  endtask

  task automatic offer_item(input track_item_t it, input bit typed, input match_t typed_res);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.action    <= it.action;
    in_if.latitude  <= it.latitude;
    in_if.longitude <= it.longitude;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_match(it, typed, typed_res);
    if (it.action != ACT_UNUSED) sent_items++;
  endtask

  task automatic push_item(input logic [ACT_W-1:0] act, input longint lat, input longint lon);
    track_item_t it;
    match_t      none;
    it.action          = act;
    it.latitude        = lat[LAT_W-1:0];
    it.longitude       = lon[LON_W-1:0];
    none.matched_index = '0;
    none.empty_flag    = 1'b0;
    offer_item(it, 1'b0, none);
  endtask

  task automatic drain_matches();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
  endtask

  function automatic longint rand_lat();
    return longint'($urandom_range(32'd1800000000)) - LAT_LIM;
  endfunction

  function automatic longint rand_lon();
    return longint'($urandom_range(32'd3600000000)) - LON_LIM;
  endfunction

  function automatic longint jitter(input longint span);
    return longint'($urandom_range(32'(2 * span))) - span;
  endfunction

  function automatic longint clamp(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Mostly recorded tracks followed by queries that move along them,
  // mixed with empty-store queries, duplicate points and raw noise.
  task automatic run_tracks(input int unsigned n_items);
    int unsigned goal;
    longint      rlat [$];
    longint      rlon [$];
    longint      plat;
    longint      plon;
    int          len;
    int          scale;
    int          pos;
    int          roll;
    goal = sent_items + n_items;
    while (sent_items < goal) begin
      roll = $urandom_range(99);
      if (roll < 72) begin
        if ($urandom_range(9) != 0 || rlat.size() > 1000) begin
          push_item(ACT_CLEAR, rand_lat(), rand_lon());
          rlat.delete();
          rlon.delete();
        end
        len = ($urandom_range(9) != 0) ? $urandom_range(40, 1) : $urandom_range(160, 41);
        case ($urandom_range(3))
          0:       scale = 50;
          1:       scale = 20000;
          2:       scale = 3000000;
          default: scale = 400000000;
        endcase
        if ($urandom_range(4) == 0) begin
          plat = $urandom_range(1) ? LAT_LIM : -LAT_LIM;
          plon = $urandom_range(1) ? LON_LIM : -LON_LIM;
        end else begin
          plat = rand_lat();
          plon = rand_lon();
        end
        repeat (len) begin
          push_item(ACT_APPEND, plat, plon);
          rlat = {rlat, plat};
          rlon = {rlon, plon};
          plat = clamp(plat + jitter(scale), LAT_LIM);
          plon = clamp(plon + jitter(scale), LON_LIM);
        end
        pos = 0;
        repeat ($urandom_range(len + 4, 1)) begin
          roll = $urandom_range(99);
          if (roll < 80) begin
            pos = pos + $urandom_range(2);
            if (pos >= rlat.size()) pos = rlat.size() - 1;
            if ($urandom_range(3) == 0) begin
              push_item(ACT_QUERY, rlat[pos], rlon[pos]);
            end else begin
              push_item(ACT_QUERY, clamp(rlat[pos] + jitter(scale / 2 + 1), LAT_LIM),
                        clamp(rlon[pos] + jitter(scale / 2 + 1), LON_LIM));
            end
          end else if (roll < 88) begin
            push_item(ACT_QUERY, rand_lat(), rand_lon());
          end else if (roll < 94) begin
            push_item(ACT_APPEND, plat, plon);
            rlat = {rlat, plat};
            rlon = {rlon, plon};
            plat = clamp(plat + jitter(scale), LAT_LIM);
            plon = clamp(plon + jitter(scale), LON_LIM);
          end else if (roll < 97) begin
            push_item(ACT_UNUSED, rand_lat(), rand_lon());
          end else begin
            // jump back behind the cursor
            pos = 0;
            push_item(ACT_QUERY, rlat[0], rlon[0]);
          end
        end
      end else if (roll < 82) begin
        push_item(ACT_CLEAR, rand_lat(), rand_lon());
        rlat.delete();
        rlon.delete();
        repeat ($urandom_range(3, 1)) push_item(ACT_QUERY, rand_lat(), rand_lon());
      end else if (roll < 90) begin
        // repeated point, so distances tie
        plat = rand_lat();
        plon = rand_lon();
        repeat ($urandom_range(5, 2)) begin
          push_item(ACT_APPEND, plat, plon);
          rlat = {rlat, plat};
          rlon = {rlon, plon};
        end
        push_item(ACT_QUERY, plat, plon);
      end else begin
        push_item(ACT_W'($urandom_range(ACT_UNUSED)), rand_lat(), rand_lon());
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_forward_nearest_point_matcher NOT OK");
      $finish;
    end
  end

  // result side: check each transfer, then pick ready for the next edge
  initial begin
    match_t want;
    int     hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pending_matches.size() == 0) begin
          report_mismatch($sformatf("unexpected result index %0d empty %0b",
                                    out_if.matched_index, out_if.empty_flag));
        end else begin
          want = pending_matches.pop_front();
          if (out_if.matched_index !== want.matched_index) begin
            report_mismatch($sformatf("matched_index %0d, want %0d",
                                      out_if.matched_index, want.matched_index));
          end
          if (out_if.empty_flag !== want.empty_flag) begin
            report_mismatch($sformatf("empty_flag %0b, want %0b",
                                      out_if.empty_flag, want.empty_flag));
          end
        end
      end
      if (hold_rx_req) begin
        hold_left   = RX_HOLD_CYCLES;
        hold_rx_req = 1'b0;
      end
      if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    track_item_t it;
    match_t      fix;
    in_if.valid     <= 1'b0;
    in_if.action    <= ACT_CLEAR;
    in_if.latitude  <= '0;
    in_if.longitude <= '0;
    rst_n           <= 1'b0;
    tx_idle_pct = 38;
    rx_idle_pct = 80;
    trk_count   = 0;
    trk_cursor  = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      it.action         = dir_tab[r].action;
      it.latitude       = dir_tab[r].latitude;
      it.longitude      = dir_tab[r].longitude;
      fix.matched_index = dir_tab[r].matched_index;
      fix.empty_flag    = dir_tab[r].empty_flag;
      offer_item(it, dir_tab[r].typed, fix);
    end
    run_tracks(500);
    drain_matches();

    tx_idle_pct = 80;
    rx_idle_pct = 38;
    run_tracks(500);
    drain_matches();

    // receiver held off while the sender keeps offering transfers
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_rx_req = 1'b1;
    run_tracks(100);
    drain_matches();

    run_tracks(500);
    drain_matches();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("tb_forward_nearest_point_matcher OK");
    end else begin
      $display("tb_forward_nearest_point_matcher NOT OK");
    end
    $finish;
  end

endmodule
